// ----- rtl/running_median_two_heaps_assert.svh -----
// Assertion macros shared by the running median checker.
// No dependencies.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_ASSERT_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_ASSERT_SVH

// implication checked on every clock, masked in reset
`define RM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rmth_pkg.sv -----
// Shared constants and types for the running median block.
// No dependencies.
package rmth_pkg;
    localparam int HALF_CAPACITY_DEF = 1024;
    localparam int SAMPLE_BITS_DEF   = 32;
    localparam int MEDIAN_W          = 33;
    localparam int COUNT_W           = 12;
    localparam int IN_W              = 32;

    // datapath operation codes
    typedef enum logic [2:0] {
        OP_NONE,
        OP_START,     // latch sample, read both tops
        OP_SIFT_STEP, // one level of the current sift
        OP_MED_READ,  // read both tops for result
        OP_MED_DONE   // form result
    } rmth_op_t;

    typedef struct packed {
        logic busy;   // tops read or sift running
        logic done;   // result register loaded
    } rmth_stat_t;
endpackage

// ----- rtl/rmth_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module rmth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/rmth_datapath.sv -----
// Heap datapath: two heap RAMs, sizes, sift engine and result forming.
// Depends on rmth_pkg and rmth_ram.
module rmth_datapath
    import rmth_pkg::*;
#(
    parameter int HALF_CAPACITY = HALF_CAPACITY_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rmth_op_t                   op,
    input  logic [SAMPLE_BITS-1:0]     sample,
    output rmth_stat_t                 stat,
    output logic signed [MEDIAN_W-1:0] median_twice,
    output logic [COUNT_W-1:0]         held_count,
    output logic                       dropped
);
    localparam int AW = $clog2(HALF_CAPACITY);
    localparam int SW = $clog2(HALF_CAPACITY + 1);
    localparam int PW = AW + 2; // positions up to 2*pos+2

    typedef enum logic [3:0] {
        S_IDLE, S_TOPS, S_DECIDE,
        S_UP_RD, S_UP_CMP,
        S_DN_RD, S_DN_RD2, S_DN_CMP,
        S_PUSH2
    } sift_t;

    sift_t state_reg;
    logic [SW-1:0] lsize_reg, usize_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg, val_reg, moved_reg;
    logic signed [SAMPLE_BITS-1:0] ltop_reg, utop_reg;
    logic [PW-1:0] pos_reg, n_reg;
    logic heap_reg;     // 1 = lower (max) heap
    logic push2_reg;    // after sift-down, push moved to other heap
    logic drop_reg;
    logic signed [MEDIAN_W-1:0] med_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic done_reg;
    logic signed [SAMPLE_BITS-1:0] cl_reg; // left child value

    // RAM ports
    logic          l_we, u_we;
    logic [AW-1:0] l_wa, u_wa, l_ra, u_ra;
    logic [SAMPLE_BITS-1:0] l_wd, u_wd, l_rd, u_rd;
    logic [AW-1:0] raddr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [SAMPLE_BITS-1:0] wdata;

    rmth_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HALF_CAPACITY)) u_lo (
        .aclk(aclk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
    rmth_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HALF_CAPACITY)) u_hi (
        .aclk(aclk), .we(u_we), .waddr(u_wa), .wdata(u_wd), .raddr(u_ra), .rdata(u_rd));

    assign l_we = we && heap_reg;
    assign u_we = we && !heap_reg;
    assign l_wa = waddr;
    assign u_wa = waddr;
    assign l_wd = wdata;
    assign u_wd = wdata;
    assign l_ra = raddr;
    assign u_ra = raddr;

    logic signed [SAMPLE_BITS-1:0] rd;
    assign rd = heap_reg ? $signed(l_rd) : $signed(u_rd);

    function automatic logic outranks(input logic is_max,
                                      input logic signed [SAMPLE_BITS-1:0] a,
                                      input logic signed [SAMPLE_BITS-1:0] b);
        outranks = is_max ? (a > b) : (a < b);
    endfunction

    logic [PW-1:0] parent, lchild, rchild;
    assign parent = (pos_reg - PW'(1)) >> 1;
    assign lchild = {pos_reg[PW-2:0], 1'b1};
    assign rchild = lchild + PW'(1);

    // best of hole value and its children during sift-down
    logic signed [SAMPLE_BITS-1:0] best_v;
    logic [PW-1:0] best_p;
    logic has_l, has_r;

    always_comb begin
        has_l  = lchild < n_reg;
        has_r  = rchild < n_reg;
        best_v = val_reg;
        best_p = pos_reg;
        if (has_l && outranks(heap_reg, cl_reg, best_v)) begin
            best_v = cl_reg;
            best_p = lchild;
        end
        if (has_r && outranks(heap_reg, rd, best_v)) begin
            best_v = rd;
            best_p = rchild;
        end
    end

    // read address and write controls
    always_comb begin
        raddr = '0;
        we    = 1'b0;
        waddr = pos_reg[AW-1:0];
        wdata = val_reg;
        unique case (state_reg)
            S_UP_RD:  raddr = parent[AW-1:0];
            S_DN_RD:  raddr = lchild[AW-1:0];
            S_DN_RD2: raddr = rchild[AW-1:0];
            default:  raddr = '0;
        endcase
        if (state_reg == S_UP_CMP) begin
            we = 1'b1;
            if (pos_reg != '0 && outranks(heap_reg, val_reg, rd)) begin
                wdata = rd;            // parent moves down
            end
        end
        if (state_reg == S_DN_CMP) begin
            we    = 1'b1;
            wdata = best_v;            // winner moves up into the hole
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            lsize_reg <= '0;
            usize_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (op == OP_START) begin
                        x_reg     <= $signed(sample);
                        heap_reg  <= 1'b1;
                        done_reg  <= 1'b0;
                        state_reg <= S_TOPS;
                    end else if (op == OP_MED_READ) begin
                        state_reg <= S_TOPS;
                        heap_reg  <= 1'b0; // marks result read
                    end
                    if (op == OP_MED_DONE) begin
                        // result from registered tops
                        if (lsize_reg == usize_reg + SW'(1) || usize_reg == '0) begin
                            med_reg <= MEDIAN_W'(ltop_reg) + MEDIAN_W'(ltop_reg);
                        end else begin
                            med_reg <= MEDIAN_W'(ltop_reg) + MEDIAN_W'(utop_reg);
                        end
                        cnt_reg  <= COUNT_W'(lsize_reg) + COUNT_W'(usize_reg);
                        done_reg <= 1'b1;
                    end
                end
                S_TOPS: begin
                    // raddr 0 issued last cycle on both RAMs
                    state_reg <= S_DECIDE;
                end
                S_DECIDE: begin
                    ltop_reg <= $signed(l_rd);
                    utop_reg <= $signed(u_rd);
                    push2_reg <= 1'b0;
                    if (!heap_reg) begin
                        state_reg <= S_IDLE;   // tops latched for result
                    end else if ({1'b0, lsize_reg} + {1'b0, usize_reg}
                                 >= (SW+1)'(2 * HALF_CAPACITY)) begin
                        drop_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        drop_reg <= 1'b0;
                        if (lsize_reg == '0 || x_reg <= $signed(l_rd)) begin
                            if (lsize_reg == usize_reg + SW'(1)) begin
                                // replace lower top, then push old top up
                                heap_reg  <= 1'b1;
                                val_reg   <= x_reg;
                                moved_reg <= $signed(l_rd);
                                pos_reg   <= '0;
                                n_reg     <= PW'(lsize_reg);
                                push2_reg <= 1'b1;
                                state_reg <= S_DN_RD;
                            end else begin
                                heap_reg  <= 1'b1;
                                val_reg   <= x_reg;
                                pos_reg   <= PW'(lsize_reg);
                                lsize_reg <= lsize_reg + SW'(1);
                                state_reg <= S_UP_RD;
                            end
                        end else if (usize_reg == lsize_reg) begin
                            if (usize_reg == '0 || x_reg <= $signed(u_rd)) begin
                                heap_reg  <= 1'b1;
                                val_reg   <= x_reg;
                                pos_reg   <= PW'(lsize_reg);
                                lsize_reg <= lsize_reg + SW'(1);
                                state_reg <= S_UP_RD;
                            end else begin
                                heap_reg  <= 1'b0;
                                val_reg   <= x_reg;
                                moved_reg <= $signed(u_rd);
                                pos_reg   <= '0;
                                n_reg     <= PW'(usize_reg);
                                push2_reg <= 1'b1;
                                state_reg <= S_DN_RD;
                            end
                        end else begin
                            heap_reg  <= 1'b0;
                            val_reg   <= x_reg;
                            pos_reg   <= PW'(usize_reg);
                            usize_reg <= usize_reg + SW'(1);
                            state_reg <= S_UP_RD;
                        end
                    end
                end
                S_UP_RD: state_reg <= S_UP_CMP;
                S_UP_CMP: begin
                    if (pos_reg != '0 && outranks(heap_reg, val_reg, rd)) begin
                        pos_reg   <= parent;
                        state_reg <= S_UP_RD;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_DN_RD:  state_reg <= S_DN_RD2;
                S_DN_RD2: begin
                    cl_reg    <= rd;
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    // write winner at pos (val itself if no child wins)
                    if (best_p != pos_reg) begin
                        pos_reg   <= best_p;
                        state_reg <= S_DN_RD;
                    end else if (push2_reg) begin
                        state_reg <= S_PUSH2;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_PUSH2: begin
                    heap_reg <= !heap_reg;
                    val_reg  <= moved_reg;
                    push2_reg <= 1'b0;
                    if (heap_reg) begin
                        pos_reg   <= PW'(usize_reg);
                        usize_reg <= usize_reg + SW'(1);
                    end else begin
                        pos_reg   <= PW'(lsize_reg);
                        lsize_reg <= lsize_reg + SW'(1);
                    end
                    state_reg <= S_UP_RD;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign stat         = '{busy: (state_reg != S_IDLE), done: done_reg};
    assign median_twice = med_reg;
    assign held_count   = cnt_reg;
    assign dropped      = drop_reg;
endmodule

// ----- rtl/rmth_ctrl.sv -----
// Controller: sequences one sample through insert, result read and output.
// Depends on rmth_pkg.
module rmth_ctrl
    import rmth_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_fire,
    input  logic       out_free,
    input  rmth_stat_t stat,
    output logic       s_ready,
    output rmth_op_t   op,
    output logic       load_out
);
    typedef enum logic [2:0] {C_IDLE, C_INS, C_RD, C_RDW, C_FORM, C_OUT} ctrl_t;
    ctrl_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            unique case (state_reg)
                C_IDLE:  if (s_fire) state_reg <= C_INS;
                C_INS:   if (!stat.busy) state_reg <= C_RD;
                C_RD:    state_reg <= C_RDW;
                C_RDW:   if (!stat.busy) state_reg <= C_FORM;
                C_FORM:  state_reg <= C_OUT;
                C_OUT:   if (out_free) state_reg <= C_IDLE;
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    always_comb begin
        unique case (state_reg)
            C_IDLE:  op = s_fire ? OP_START : OP_NONE;
            C_RD:    op = OP_MED_READ;
            C_FORM:  op = OP_MED_DONE;
            default: op = OP_NONE;
        endcase
    end

    // done stays up until the next sample starts, so a stalled output still loads
    assign s_ready  = (state_reg == C_IDLE);
    assign load_out = (state_reg == C_OUT) && out_free && stat.done;
endmodule

// ----- rtl/running_median_two_heaps.sv -----
// Top level of the running median: stream ports, controller, datapath.
// Depends on rmth_pkg, rmth_ctrl, rmth_datapath.
//  channel | dir | tdata fields (low to high)                  | tuser
//  s_      | in  | sample[31:0]                                | -
//  m_      | out | median_twice[32:0], held_count[44:33], pad   | dropped
// A sample passes handshake and control, then its sift: a level going up reads
// the parent, then compares and writes; a level going down reads both children,
// then compares and writes; a top handed across then sifts up the other heap.
// Each sift step waits on a registered RAM read; a dropped sample has no sift.
// Reset is synchronous; heap RAMs need no clearing.
// A beat waits in the output register until m_tready; the next sample may enter
// meanwhile, but its result is held back until the register is free.
module running_median_two_heaps
    import rmth_pkg::*;
#(
    parameter int HALF_CAPACITY = HALF_CAPACITY_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // median_twice, held_count, zero pad
    output logic        m_tuser    // dropped
);
    rmth_op_t   op;
    rmth_stat_t stat;
    logic       load_out, out_free;
    logic signed [MEDIAN_W-1:0] med;
    logic [COUNT_W-1:0] cnt;
    logic drop;
    logic       m_tvalid_reg;
    logic [47:0] m_tdata_reg;
    logic        m_tuser_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    rmth_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_fire(s_tvalid && s_tready),
        .out_free(out_free), .stat(stat), .s_ready(s_tready), .op(op),
        .load_out(load_out));

    rmth_datapath #(.HALF_CAPACITY(HALF_CAPACITY), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .op(op), .sample(s_tdata[SAMPLE_BITS-1:0]),
        .stat(stat), .median_twice(med), .held_count(cnt), .dropped(drop));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
            m_tdata_reg  <= {3'b000, cnt, med};
            m_tuser_reg  <= drop;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
endmodule

// ----- rtl/rmth_checker.sv -----
// Port-level checker for the running median, bound to the top level.
// Depends on running_median_two_heaps_assert.svh.
`include "running_median_two_heaps_assert.svh"
module rmth_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);
    `RM_ASSERT_NEXT(a_one_result, aclk, aresetn, s_tvalid && s_tready, !s_tready, "busy after accept")
    `RM_ASSERT_IMP(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[47:45] == 3'b000, "pad bits set")
    `RM_ASSERT_IMP(a_count_pos, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[44:33] != 12'd0, "zero count")
    `RM_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "beat changed")
endmodule

bind running_median_two_heaps rmth_checker u_rmth_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser));
